FILE: hw/rtl/chm_pkg.sv
package chm_pkg;

  // Field widths
  localparam int unsigned PosW   = 20;
  localparam int unsigned ErrW   = 16;
  localparam int unsigned TagW   = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned ConfW  = 32;
  localparam int unsigned WgtW   = 48;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // Divider geometry: all three dividers share one quotient length
  localparam int unsigned QuotW  = 48;
  localparam int unsigned ConfNW = 56;
  localparam int unsigned ConfDW = 43;
  localparam int unsigned WgtNW  = 92;
  localparam int unsigned WgtDW  = 66;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegVertexX   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegVertexY   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegErrorScale = 2'd2;

  localparam logic [ScaleW-1:0] ScaleReset  = 16'd256;
  localparam logic [ConfW-1:0]  ConfPosMax  = 32'h7FFF_FFFF;
  localparam logic [ConfW-1:0]  ConfNegMax  = 32'h8000_0000;
  localparam logic [WgtW-1:0]   WeightMax   = 48'hFFFF_FFFF_FFFF;

  // Per-hit flags and pass-through fields
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic            last;
    logic            neg_x;
    logic            neg_y;
    logic            rad_zero;
    logic            err_zero;
    logic            w_max;
  } chm_side_t;

endpackage

FILE: hw/rtl/chm_div_pipe.sv
module chm_div_pipe import chm_pkg::*; #(
  parameter int unsigned NW = ConfNW,
  parameter int unsigned DW = ConfDW,
  parameter int unsigned QW = QuotW,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic          sat_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned MW = (NW > DW + QW) ? NW : DW + QW;

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] nlo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW+1];
  logic          sat_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];
  logic          v_q    [QW+1];

  // Entry stage: flag quotients that overflow QW bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= MW'(num_i) >= (MW'(den_i) << QW);
      rem_q[0]  <= DW'(num_i >> QW);
      nlo_q[0]  <= num_i[QW-1:0];
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem_q[k], nlo_q[k][QW-1]};
    assign ge    = trial >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k+1]  <= {quo_q[k][QW-2:0], ge};
        sat_q[k+1]  <= sat_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? DW'(trial - {1'b0, den_q[k]}) : DW'(trial);
          nlo_q[k+1] <= nlo_q[k] << 1;
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = quo_q[QW];
  assign sat_o   = sat_q[QW];
  assign side_o  = side_q[QW];

endmodule

FILE: hw/rtl/chm_prep.sv
module chm_prep import chm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [PosW-1:0]     hit_x_i,
  input  logic [PosW-1:0]     hit_y_i,
  input  logic [ErrW-1:0]     err_x_i,
  input  logic [ErrW-1:0]     err_y_i,
  input  logic [TagW-1:0]     hit_tag_i,
  input  logic                event_end_i,
  input  logic [PosW-1:0]     vertex_x_i,
  input  logic [PosW-1:0]     vertex_y_i,
  input  logic [ScaleW-1:0]   error_scale_i,
  output logic                valid_o,
  output logic [ConfNW-1:0]   num_x_o,
  output logic [ConfNW-1:0]   num_y_o,
  output logic [ConfDW-1:0]   den_c_o,
  output logic [WgtNW-1:0]    num_w_o,
  output logic [WgtDW-1:0]    den_w_o,
  output chm_side_t           side_o
);

  logic [5:0] v_q;
  chm_side_t  side1_q, side2_q, side3_q, side4_q, side5_q, side6_q;
  chm_side_t  side3_d, side4_d;

  logic [20:0] x_d, y_d;
  logic [20:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q, ax4_q, ay4_q, ax5_q, ay5_q;
  logic [31:0] ex2_1_q, ey2_1_q, s2_1_q, s2_2_q;
  logic [40:0] axx2_q, ayy2_q;
  logic [32:0] e2_q, e3_d;
  logic [41:0] r2_3_q, r2_4_q, r2_5_q;
  logic [47:0] ph3_q;
  logic [48:0] pl3_q;
  logic [41:0] hh4_q, hl4_q, ll4_q;
  logic [64:0] d4_q, d5_q;
  logic [83:0] sq5_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  assign x_d = {hit_x_i[PosW-1], hit_x_i} - {vertex_x_i[PosW-1], vertex_x_i};
  assign y_d = {hit_y_i[PosW-1], hit_y_i} - {vertex_y_i[PosW-1], vertex_y_i};
  assign e3_d = e2_q;

  // Merge the zero flags into the side fields as they become known
  always_comb begin
    side3_d          = side2_q;
    side3_d.err_zero = e3_d == '0;
    side3_d.w_max    = side2_q.w_max || (e3_d == '0);
    side4_d          = side3_q;
    side4_d.rad_zero = r2_3_q == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1: offset to vertex, magnitudes, error and scale squares
      ax1_q   <= x_d[20] ? 21'(0 - x_d) : x_d;
      ay1_q   <= y_d[20] ? 21'(0 - y_d) : y_d;
      ex2_1_q <= 32'(err_x_i) * 32'(err_x_i);
      ey2_1_q <= 32'(err_y_i) * 32'(err_y_i);
      s2_1_q  <= 32'(error_scale_i) * 32'(error_scale_i);
      side1_q.tag      <= hit_tag_i;
      side1_q.last     <= event_end_i;
      side1_q.neg_x    <= x_d[20];
      side1_q.neg_y    <= !y_d[20] && (y_d != '0);
      side1_q.rad_zero <= 1'b0;
      side1_q.err_zero <= 1'b0;
      side1_q.w_max    <= error_scale_i == '0;

      // Stage 2: position squares, error sum
      axx2_q  <= 41'(ax1_q) * 41'(ax1_q);
      ayy2_q  <= 41'(ay1_q) * 41'(ay1_q);
      e2_q    <= 33'(ex2_1_q) + 33'(ey2_1_q);
      s2_2_q  <= s2_1_q;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      side2_q <= side1_q;

      // Stage 3: radius squared, denominator partial products
      r2_3_q  <= 42'(axx2_q) + 42'(ayy2_q);
      ph3_q   <= 48'(s2_2_q) * 48'(e3_d[32:17]);
      pl3_q   <= 49'(s2_2_q) * 49'(e3_d[16:0]);
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      side3_q <= side3_d;

      // Stage 4: r2 squared partial products, denominator sum
      hh4_q   <= 42'(r2_3_q[41:21]) * 42'(r2_3_q[41:21]);
      hl4_q   <= 42'(r2_3_q[41:21]) * 42'(r2_3_q[20:0]);
      ll4_q   <= 42'(r2_3_q[20:0]) * 42'(r2_3_q[20:0]);
      d4_q    <= (65'(ph3_q) << 17) + 65'(pl3_q);
      r2_4_q  <= r2_3_q;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      side4_q <= side4_d;

      // Stage 5: sum r2 squared
      sq5_q   <= (84'(hh4_q) << 42) + (84'(hl4_q) << 22) + 84'(ll4_q);
      d5_q    <= d4_q;
      r2_5_q  <= r2_4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
      side5_q <= side4_q;

      // Stage 6: form dividends and divisors with rounding terms
      num_x_o <= (ConfNW'(ax5_q) << 35) + ConfNW'(r2_5_q);
      num_y_o <= (ConfNW'(ay5_q) << 35) + ConfNW'(r2_5_q);
      den_c_o <= {r2_5_q, 1'b0};
      num_w_o <= (WgtNW'(sq5_q) << 9) + WgtNW'(d5_q);
      den_w_o <= {d5_q, 1'b0};
      side6_q <= side5_q;
    end
  end

  assign valid_o = v_q[5];
  assign side_o  = side6_q;

endmodule

FILE: hw/rtl/conformal_hit_mapping_top.sv
// Conformal hit mapping pipeline.
// Input channel: in_valid_i with hit_x_i, hit_y_i, err_x_i, err_y_i, hit_tag_i,
// event_end_i; a transfer happens when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o with conf_x_o, conf_y_o, fit_weight_o, the
// zero flags, tag_out_o and end_out_o; a transfer happens when out_valid_o is
// high and out_stall_i low. Every hit yields exactly one result, in order.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (vertex x, vertex y, error scale); write only while the pipe is empty.
// Throughput: one hit per cycle while the receiver does not stall. A hit
// passes the squaring and partial-product stages, the bit-per-stage restoring
// dividers (one overflow check, 48 quotient bits) and one output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises; no item is lost or repeated.
// Reset clears all valid bits and sets vertex 0,0 and error scale 1.0.
module conformal_hit_mapping_top import chm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PosW-1:0]     hit_x_i,
  input  logic [PosW-1:0]     hit_y_i,
  input  logic [ErrW-1:0]     err_x_i,
  input  logic [ErrW-1:0]     err_y_i,
  input  logic [TagW-1:0]     hit_tag_i,
  input  logic                event_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ConfW-1:0]    conf_x_o,
  output logic [ConfW-1:0]    conf_y_o,
  output logic [WgtW-1:0]     fit_weight_o,
  output logic                radius_zero_o,
  output logic                error_zero_o,
  output logic [TagW-1:0]     tag_out_o,
  output logic                end_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SideW = $bits(chm_side_t);

  logic              en;
  logic [PosW-1:0]   vertex_x_q, vertex_y_q;
  logic [ScaleW-1:0] error_scale_q;

  logic              p_valid;
  logic [ConfNW-1:0] p_num_x, p_num_y;
  logic [ConfDW-1:0] p_den_c;
  logic [WgtNW-1:0]  p_num_w;
  logic [WgtDW-1:0]  p_den_w;
  chm_side_t         p_side;

  logic              vx_valid, vy_valid, w_valid;
  logic [QuotW-1:0]  qx, qy, qw;
  logic              sx, sy, sw;
  logic              nx, ny;
  logic [SideW-1:0]  w_side_raw;
  chm_side_t         w_side;

  logic [ConfW-1:0]  cx_d, cy_d;
  logic [WgtW-1:0]   w_d;
  logic              out_valid_q;

  // Hold everything while a result waits on a stalled receiver
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_x_q    <= '0;
      vertex_y_q    <= '0;
      error_scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVertexX:    vertex_x_q    <= cfg_data_i;
        RegVertexY:    vertex_y_q    <= cfg_data_i;
        RegErrorScale: error_scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  chm_prep u_prep (
    .clk_i, .rst_ni,
    .en_i          (en),
    .valid_i       (in_valid_i),
    .hit_x_i, .hit_y_i, .err_x_i, .err_y_i, .hit_tag_i, .event_end_i,
    .vertex_x_i    (vertex_x_q),
    .vertex_y_i    (vertex_y_q),
    .error_scale_i (error_scale_q),
    .valid_o       (p_valid),
    .num_x_o       (p_num_x),
    .num_y_o       (p_num_y),
    .den_c_o       (p_den_c),
    .num_w_o       (p_num_w),
    .den_w_o       (p_den_w),
    .side_o        (p_side)
  );

  chm_div_pipe #(.NW(ConfNW), .DW(ConfDW), .QW(QuotW), .SW(1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_valid),
    .num_i(p_num_x), .den_i(p_den_c), .side_i(p_side.neg_x),
    .valid_o(vx_valid), .quot_o(qx), .sat_o(sx), .side_o(nx)
  );

  chm_div_pipe #(.NW(ConfNW), .DW(ConfDW), .QW(QuotW), .SW(1)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_valid),
    .num_i(p_num_y), .den_i(p_den_c), .side_i(p_side.neg_y),
    .valid_o(vy_valid), .quot_o(qy), .sat_o(sy), .side_o(ny)
  );

  chm_div_pipe #(.NW(WgtNW), .DW(WgtDW), .QW(QuotW), .SW(SideW)) u_div_w (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_valid),
    .num_i(p_num_w), .den_i(p_den_w), .side_i(p_side),
    .valid_o(w_valid), .quot_o(qw), .sat_o(sw), .side_o(w_side_raw)
  );

  assign w_side = chm_side_t'(w_side_raw);

  // Saturate and sign the quotients
  always_comb begin
    if (w_side.rad_zero) begin
      cx_d = ConfPosMax;
    end else if (!nx) begin
      cx_d = (sx || qx > QuotW'(ConfPosMax)) ? ConfPosMax : qx[ConfW-1:0];
    end else begin
      cx_d = (sx || qx > QuotW'(ConfNegMax)) ? ConfNegMax : ConfW'(0 - qx[ConfW-1:0]);
    end

    if (w_side.rad_zero) begin
      cy_d = ConfPosMax;
    end else if (!ny) begin
      cy_d = (sy || qy > QuotW'(ConfPosMax)) ? ConfPosMax : qy[ConfW-1:0];
    end else begin
      cy_d = (sy || qy > QuotW'(ConfNegMax)) ? ConfNegMax : ConfW'(0 - qy[ConfW-1:0]);
    end

    w_d = (w_side.w_max || sw) ? WeightMax : qw[WgtW-1:0];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= w_valid && vx_valid && vy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      conf_x_o      <= cx_d;
      conf_y_o      <= cy_d;
      fit_weight_o  <= w_d;
      radius_zero_o <= w_side.rad_zero;
      error_zero_o  <= w_side.err_zero;
      tag_out_o     <= w_side.tag;
      end_out_o     <= w_side.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
